### design/vfcm_pkg.sv
// Shared types, constants, tables and control program of the voxel face-culling mesher.
package vfcm_pkg;

  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;

  localparam int AREA_X      = SIZE_Y * SIZE_Z;
  localparam int AREA_Y      = SIZE_X * SIZE_Z;
  localparam int AREA_Z      = SIZE_X * SIZE_Y;
  localparam int CHUNK_CELLS = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int PLANE_CELLS = 2 * (AREA_X + AREA_Y + AREA_Z);
  localparam int CHUNK_AW    = $clog2(CHUNK_CELLS);
  localparam int PLANE_AW    = $clog2(PLANE_CELLS);

  localparam int CW    = 4;
  localparam int FACES = 6;
  localparam int VERTS = 6;
  localparam int PC_W  = 4;

  localparam logic [2:0] VTX_LAST = 3'(VERTS - 1);

  // Item operations
  localparam logic [1:0] OP_WRITE_CHUNK = 2'd0;
  localparam logic [1:0] OP_WRITE_PLANE = 2'd1;
  localparam logic [1:0] OP_MESH        = 2'd2;
  localparam logic [1:0] OP_NOP         = 2'd3;

  // Block kinds
  localparam logic [1:0] KIND_AIR   = 2'd0;
  localparam logic [1:0] KIND_GRASS = 2'd1;
  localparam logic [1:0] KIND_DIRT  = 2'd2;
  localparam logic [1:0] KIND_STONE = 2'd3;

  // Directions and faces
  localparam logic [2:0] DIR_NX = 3'd0;
  localparam logic [2:0] DIR_PX = 3'd1;
  localparam logic [2:0] DIR_NY = 3'd2;
  localparam logic [2:0] DIR_PY = 3'd3;
  localparam logic [2:0] DIR_NZ = 3'd4;
  localparam logic [2:0] DIR_PZ = 3'd5;

  // Atlas rows
  localparam logic [4:0] ROW_GRASS_SIDE = 5'(0 * 6);
  localparam logic [4:0] ROW_GRASS_TOP  = 5'(1 * 6);
  localparam logic [4:0] ROW_DIRT       = 5'(2 * 6);
  localparam logic [4:0] ROW_STONE      = 5'(3 * 6);

  // Program counter layout
  localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
  localparam logic [PC_W-1:0] PC_WRITE = 4'd1;
  localparam logic [PC_W-1:0] PC_MESH  = 4'd2;
  localparam logic [PC_W-1:0] PC_ADJ0  = 4'd3;
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT0 = 4'd10;
  localparam logic [PC_W-1:0] PC_LAST  = 4'd15;

  typedef struct packed {
    logic [1:0]    op;
    logic [CW-1:0] voxel_x;
    logic [CW-1:0] voxel_y;
    logic [CW-1:0] voxel_z;
    logic [2:0]    plane_dir;
    logic [1:0]    block_kind;
  } in_item_t;

  typedef struct packed {
    logic [4:0] corner_x;
    logic [4:0] corner_y;
    logic [4:0] corner_z;
    logic [4:0] atlas_index;
    logic [2:0] face_id;
    logic       last_vertex;
  } out_item_t;

  typedef enum logic [2:0] {
    U_FETCH,
    U_WRITE,
    U_READ,
    U_WAIT,
    U_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    SRC_AIR,
    SRC_CHUNK,
    SRC_PLANE
  } src_e;

  typedef struct packed {
    uop_e            uop;
    logic            rd_center;
    logic [2:0]      face;
    logic [PC_W-1:0] next_pc;
  } uword_t;

  typedef struct packed {
    uop_e       uop;
    logic       rd_center;
    logic [2:0] face;
    logic [2:0] vtx;
    logic       accept;
    logic       load;
  } ctrl_t;

  typedef struct packed {
    logic face_vis;
    logic out_free;
  } status_t;

  // Corner offsets per face and vertex: bit0 dx, bit1 dy, bit2 dz.
  localparam logic [2:0] CORNER_TAB [FACES][VERTS] = '{
    '{3'd0, 3'd4, 3'd2, 3'd2, 3'd4, 3'd6},
    '{3'd5, 3'd1, 3'd7, 3'd7, 3'd1, 3'd3},
    '{3'd4, 3'd0, 3'd5, 3'd5, 3'd0, 3'd1},
    '{3'd2, 3'd6, 3'd3, 3'd3, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd3, 3'd3, 3'd0, 3'd2},
    '{3'd4, 3'd5, 3'd6, 3'd6, 3'd5, 3'd7}
  };

  function automatic logic [4:0] row_offset(input logic [1:0] kind, input logic [2:0] face);
    logic [4:0] row;
    row = ROW_STONE;
    if (kind == KIND_GRASS) begin
      if (face == DIR_NY) row = ROW_DIRT;
      else if (face == DIR_PY) row = ROW_GRASS_TOP;
      else row = ROW_GRASS_SIDE;
    end else if (kind == KIND_DIRT) begin
      row = ROW_DIRT;
    end
    return row;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w.uop       = U_FETCH;
    w.rd_center = 1'b0;
    w.face      = DIR_NX;
    w.next_pc   = PC_FETCH;
    if (pc == PC_FETCH) begin
      w.uop = U_FETCH;
    end else if (pc == PC_WRITE) begin
      w.uop = U_WRITE;
    end else if (pc == PC_MESH) begin
      w.uop       = U_READ;
      w.rd_center = 1'b1;
      w.next_pc   = PC_ADJ0;
    end else if (pc < PC_WAIT) begin
      w.uop     = U_READ;
      w.face    = 3'(pc - PC_ADJ0);
      w.next_pc = pc + 4'd1;
    end else if (pc == PC_WAIT) begin
      w.uop     = U_WAIT;
      w.next_pc = PC_EMIT0;
    end else begin
      w.uop     = U_EMIT;
      w.face    = 3'(pc - PC_EMIT0);
      w.next_pc = (pc == PC_LAST) ? PC_FETCH : pc + 4'd1;
    end
    return w;
  endfunction

endpackage

### design/vfcm_sequencer.sv
// Microcode sequencer: step counter, control store lookup and vertex loop counter.
module vfcm_sequencer import vfcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  status_t    status_i,
  output ctrl_t      ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic [2:0]      vtx_q, vtx_d;
  uword_t          uw;

  assign uw = ucode(pc_q);

  // Output block: decode the control word
  always_comb begin
    ctrl_o.uop       = uw.uop;
    ctrl_o.rd_center = uw.rd_center;
    ctrl_o.face      = uw.face;
    ctrl_o.vtx       = vtx_q;
    ctrl_o.accept    = (uw.uop == U_FETCH) && in_valid_i;
    ctrl_o.load      = (uw.uop == U_EMIT) && status_i.face_vis && status_i.out_free;
  end

  // Next step block
  always_comb begin
    pc_d  = uw.next_pc;
    vtx_d = vtx_q;
    case (uw.uop)
      U_FETCH: begin
        pc_d = PC_FETCH;
        if (in_valid_i) begin
          if (in_op_i == OP_MESH) pc_d = PC_MESH;
          else if (in_op_i == OP_WRITE_CHUNK || in_op_i == OP_WRITE_PLANE) pc_d = PC_WRITE;
        end
      end
      U_EMIT: begin
        if (!status_i.face_vis) begin
          pc_d = uw.next_pc;
        end else if (status_i.out_free) begin
          if (vtx_q == VTX_LAST) begin
            vtx_d = 3'd0;
            pc_d  = uw.next_pc;
          end else begin
            vtx_d = vtx_q + 3'd1;
            pc_d  = pc_q;
          end
        end else begin
          pc_d = pc_q;
        end
      end
      default: pc_d = uw.next_pc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_FETCH;
      vtx_q <= 3'd0;
    end else begin
      pc_q  <= pc_d;
      vtx_q <= vtx_d;
    end
  end

endmodule

### design/vfcm_datapath.sv
// Datapath: voxel stores, neighbor lookup, visibility capture and vertex output register.
module vfcm_datapath import vfcm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic      out_stall_i,
  input  ctrl_t     ctrl_i,
  output status_t   status_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  function automatic logic [CHUNK_AW-1:0] chunk_index(input logic [CW-1:0] x,
                                                      input logic [CW-1:0] y,
                                                      input logic [CW-1:0] z);
    return CHUNK_AW'((int'(x) * SIZE_Y + int'(y)) * SIZE_Z + int'(z));
  endfunction

  // Returns {hit, address} of a boundary plane entry.
  function automatic logic [PLANE_AW:0] plane_lookup(input logic [2:0] d,
                                                     input logic [CW-1:0] x,
                                                     input logic [CW-1:0] y,
                                                     input logic [CW-1:0] z);
    logic ok;
    int   idx;
    ok  = 1'b0;
    idx = 0;
    case (d)
      DIR_NX, DIR_PX: begin
        ok  = (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z);
        idx = AREA_X * int'(d[0]) + SIZE_Z * int'(y) + int'(z);
      end
      DIR_NY, DIR_PY: begin
        ok  = (int'(x) < SIZE_X) && (int'(z) < SIZE_Z);
        idx = 2 * AREA_X + AREA_Y * int'(d[0]) + SIZE_Z * int'(x) + int'(z);
      end
      DIR_NZ, DIR_PZ: begin
        ok  = (int'(x) < SIZE_X) && (int'(y) < SIZE_Y);
        idx = 2 * (AREA_X + AREA_Y) + AREA_Z * int'(d[0]) + SIZE_Y * int'(x) + int'(y);
      end
      default: ok = 1'b0;
    endcase
    return {ok, PLANE_AW'(idx)};
  endfunction

  logic [1:0] chunk_mem [CHUNK_CELLS];
  logic [1:0] plane_mem [PLANE_CELLS];

  in_item_t   item_q;
  logic [5:0] mask_q;

  logic [CHUNK_AW-1:0] chunk_waddr, chunk_raddr;
  logic [PLANE_AW-1:0] plane_raddr;
  logic [PLANE_AW:0]   plane_wr_hit, plane_rd_hit;
  logic                chunk_we, plane_we, in_range;
  logic [1:0]          chunk_rdata_q, plane_rdata_q;

  logic          rd_pend_q, rd_center_q;
  logic [2:0]    rd_face_q;
  src_e          rd_src_q, rd_src;
  logic [1:0]    rd_kind;
  logic [1:0]    center_q;
  logic [5:0]    adj_air_q;

  logic [CW-1:0] nx, ny, nz;
  logic          at_edge;
  logic [7:0]    mask_ext, vis_ext;
  logic          above_vis;
  logic [2:0]    corner;

  logic      out_valid_q;
  out_item_t out_data_q, vertex;

  assign in_range = (int'(item_q.voxel_x) < SIZE_X) && (int'(item_q.voxel_y) < SIZE_Y)
                 && (int'(item_q.voxel_z) < SIZE_Z);

  // Write side
  assign chunk_waddr  = chunk_index(item_q.voxel_x, item_q.voxel_y, item_q.voxel_z);
  assign plane_wr_hit = plane_lookup(item_q.plane_dir, item_q.voxel_x, item_q.voxel_y,
                                     item_q.voxel_z);
  assign chunk_we = (ctrl_i.uop == U_WRITE) && (item_q.op == OP_WRITE_CHUNK) && in_range;
  assign plane_we = (ctrl_i.uop == U_WRITE) && (item_q.op == OP_WRITE_PLANE)
                 && plane_wr_hit[PLANE_AW];

  // Neighbor across the current face
  assign mask_ext     = {2'b00, mask_q};
  assign plane_rd_hit = plane_lookup(ctrl_i.face, item_q.voxel_x, item_q.voxel_y,
                                     item_q.voxel_z);
  assign plane_raddr  = plane_rd_hit[PLANE_AW-1:0];

  always_comb begin
    nx      = item_q.voxel_x;
    ny      = item_q.voxel_y;
    nz      = item_q.voxel_z;
    at_edge = 1'b1;
    case (ctrl_i.face)
      DIR_NX: begin at_edge = (item_q.voxel_x == '0); nx = item_q.voxel_x - 1'b1; end
      DIR_PX: begin at_edge = (int'(item_q.voxel_x) == SIZE_X - 1); nx = item_q.voxel_x + 1'b1; end
      DIR_NY: begin at_edge = (item_q.voxel_y == '0); ny = item_q.voxel_y - 1'b1; end
      DIR_PY: begin at_edge = (int'(item_q.voxel_y) == SIZE_Y - 1); ny = item_q.voxel_y + 1'b1; end
      DIR_NZ: begin at_edge = (item_q.voxel_z == '0); nz = item_q.voxel_z - 1'b1; end
      DIR_PZ: begin at_edge = (int'(item_q.voxel_z) == SIZE_Z - 1); nz = item_q.voxel_z + 1'b1; end
      default: at_edge = 1'b1;
    endcase
  end

  always_comb begin
    chunk_raddr = chunk_index(nx, ny, nz);
    rd_src      = SRC_AIR;
    if (ctrl_i.rd_center) begin
      chunk_raddr = chunk_waddr;
      rd_src      = SRC_CHUNK;
    end else if (!at_edge) begin
      rd_src = SRC_CHUNK;
    end else if (plane_rd_hit[PLANE_AW] && mask_ext[ctrl_i.face]) begin
      rd_src = SRC_PLANE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chunk_we) chunk_mem[chunk_waddr] <= item_q.block_kind;
    chunk_rdata_q <= chunk_mem[chunk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (plane_we) plane_mem[plane_wr_hit[PLANE_AW-1:0]] <= item_q.block_kind;
    plane_rdata_q <= plane_mem[plane_raddr];
  end

  // Capture read results in the cycle after the read
  always_comb begin
    case (rd_src_q)
      SRC_CHUNK: rd_kind = chunk_rdata_q;
      SRC_PLANE: rd_kind = plane_rdata_q;
      default:   rd_kind = KIND_AIR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 6'd0;
      rd_pend_q   <= 1'b0;
      rd_center_q <= 1'b0;
      rd_face_q   <= DIR_NX;
      rd_src_q    <= SRC_AIR;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      rd_pend_q   <= (ctrl_i.uop == U_READ);
      rd_center_q <= ctrl_i.rd_center;
      rd_face_q   <= ctrl_i.face;
      rd_src_q    <= rd_src;
      if (ctrl_i.load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) item_q <= in_data_i;
    if (rd_pend_q) begin
      if (rd_center_q) center_q <= in_range ? rd_kind : KIND_AIR;
      else adj_air_q[rd_face_q] <= (rd_kind == KIND_AIR);
    end
    if (ctrl_i.load) out_data_q <= vertex;
  end

  // Vertex generation
  assign vis_ext = {2'b00, {FACES{center_q != KIND_AIR}} & adj_air_q};

  always_comb begin
    above_vis = 1'b0;
    for (int j = 0; j < FACES; j++) begin
      if (3'(j) > ctrl_i.face) above_vis = above_vis | vis_ext[j];
    end
  end

  assign corner = CORNER_TAB[ctrl_i.face][ctrl_i.vtx];

  always_comb begin
    vertex.corner_x    = {1'b0, item_q.voxel_x} + {4'b0000, corner[0]};
    vertex.corner_y    = {1'b0, item_q.voxel_y} + {4'b0000, corner[1]};
    vertex.corner_z    = {1'b0, item_q.voxel_z} + {4'b0000, corner[2]};
    vertex.atlas_index = row_offset(center_q, ctrl_i.face) + {2'b00, ctrl_i.vtx};
    vertex.face_id     = ctrl_i.face;
    vertex.last_vertex = (ctrl_i.vtx == VTX_LAST) && !above_vis;
  end

  assign status_o.face_vis = vis_ext[ctrl_i.face];
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### design/voxel_face_cull_mesher_unit.sv
// Top level of the voxel face-culling mesher: sequencer, datapath and checks.
//
// The block keeps one 16x16x16 chunk of 2-bit voxels plus the six facing boundary
// planes of the neighbor chunks, both in single-port-write, registered-read memories
// with no reset contents: load every voxel before meshing a block that reads it.
// Each input transaction is one of: write a chunk voxel, write a neighbor plane
// voxel, or mesh the block at x,y,z; a mesh emits six vertices for each visible face
// in order -X,+X,-Y,+Y,-Z,+Z, flagging the final one. A microcoded sequencer steps
// through a sixteen-word control store and drives the datapath one step per cycle.
// A write is taken and then performed; an unused op code is only taken. A mesh takes
// the transaction, makes seven reads through the chunk and plane read ports (center
// plus six neighbors), waits for the last read to land, then steps past each hidden
// face and emits the six vertices of each visible face, one vertex per cycle out of
// the output register while the output is not stalled; output stall holds the emit step. The
// neighbor_present_mask register may be written only while the block is idle.
module voxel_face_cull_mesher_unit import vfcm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ctrl_t   ctrl;
  status_t status;

  vfcm_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  vfcm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Take a new transaction only on the fetch step.
  assign in_stall_o = (ctrl.uop != U_FETCH);

  // Vertex loop counter stays within one face.
  a_vtx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.vtx <= VTX_LAST)
    else $error("vertex counter out of range");

  // Idle means the vertex loop has wrapped back to zero.
  a_idle_vtx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> ctrl.vtx == 3'd0)
    else $error("vertex counter not cleared at fetch");

  // A write or mesh transaction holds off the next one.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.op != OP_NOP) |=> in_stall_o)
    else $error("accepted a transaction while busy");

  // Vertices load only on emit steps.
  a_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> (ctrl.uop == U_EMIT && in_stall_o))
    else $error("vertex load outside emit step");

endmodule

### test/tb_top.sv
// Testbench for the voxel face-culling mesher: queued loads and meshes checked vertex by vertex.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 64;    // longer than the slowest mesh with no output
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 14;
  localparam int MAX_REPORTS  = 40;
  localparam int KEEP         = -1;    // mesh_block: keep stored kinds, fill gaps at random

  localparam int PLANE_SLOTS = (AREA_X > AREA_Y) ? ((AREA_X > AREA_Z) ? AREA_X : AREA_Z)
                                                 : ((AREA_Y > AREA_Z) ? AREA_Y : AREA_Z);

  // Plane directions past +Z: the block must drop such writes.
  localparam logic [2:0] DIR_BAD_LO = 3'd6;
  localparam logic [2:0] DIR_BAD_HI = 3'd7;

  // Corner of each vertex per face: bit0 adds 1 to x, bit1 to y, bit2 to z.
  localparam logic [2:0] VERTEX_CORNER [FACES][VERTS] = '{
    '{3'd0, 3'd4, 3'd2, 3'd2, 3'd4, 3'd6},
    '{3'd5, 3'd1, 3'd7, 3'd7, 3'd1, 3'd3},
    '{3'd4, 3'd0, 3'd5, 3'd5, 3'd0, 3'd1},
    '{3'd2, 3'd6, 3'd3, 3'd3, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd3, 3'd3, 3'd0, 3'd2},
    '{3'd4, 3'd5, 3'd6, 3'd6, 3'd5, 3'd7}
  };

  // Every input of the block starts at a known value.
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  // Shadow of the block's storage and register, updated as transactions are accepted.
  logic [1:0] vox_mem   [CHUNK_CELLS];
  logic [1:0] plane_mem [FACES][PLANE_SLOTS];
  logic [5:0] pred_mask = '0;

  // Generator bookkeeping: which entries the queued stimulus has already loaded.
  bit vox_set   [CHUNK_CELLS];
  bit plane_set [FACES][PLANE_SLOTS];

  in_item_t  pending_items[$];
  out_item_t expected_vertices[$];

  int error_count   = 0;
  int vertices_seen = 0;
  int cycle_count   = 0;
  int in_gap        = 0;
  int stall_left    = 0;
  logic rand_stall  = 1'b0;
  bit pressure_armed = 1'b0;
  int hold_count    = 0;
  logic hold_active = 1'b0;

  voxel_face_cull_mesher_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic int voxel_addr(int x, int y, int z);
    return (x * SIZE_Y + y) * SIZE_Z + z;
  endfunction

  // Plane entry for direction dir: indexed by the two coordinates off that direction's axis.
  function automatic int plane_slot(logic [2:0] dir, int x, int y, int z);
    int slot;
    case (dir)
      DIR_NX, DIR_PX: slot = y * SIZE_Z + z;
      DIR_NY, DIR_PY: slot = x * SIZE_Z + z;
      default:        slot = x * SIZE_Y + y;
    endcase
    return slot;
  endfunction

  // Move one voxel across face; return 1 when that leaves the chunk.
  function automatic bit step_face(input logic [2:0] face, input int x, input int y,
                                   input int z, output int nx, output int ny, output int nz);
    bit outside;
    nx = x;
    ny = y;
    nz = z;
    case (face)
      DIR_NX: begin
        outside = (x == 0);
        nx = x - 1;
      end
      DIR_PX: begin
        outside = (x == SIZE_X - 1);
        nx = x + 1;
      end
      DIR_NY: begin
        outside = (y == 0);
        ny = y - 1;
      end
      DIR_PY: begin
        outside = (y == SIZE_Y - 1);
        ny = y + 1;
      end
      DIR_NZ: begin
        outside = (z == 0);
        nz = z - 1;
      end
      default: begin
        outside = (z == SIZE_Z - 1);
        nz = z + 1;
      end
    endcase
    return outside;
  endfunction

  // Kind seen across face: chunk voxel inside, neighbor plane at the edge, air if absent.
  function automatic logic [1:0] neighbor_kind(logic [2:0] face, int x, int y, int z);
    int nx, ny, nz;
    if (!step_face(face, x, y, z, nx, ny, nz)) return vox_mem[voxel_addr(nx, ny, nz)];
    if (!pred_mask[face]) return KIND_AIR;
    return plane_mem[face][plane_slot(face, x, y, z)];
  endfunction

  // Grass has a top, a dirt bottom and sides; dirt and stone look the same all round.
  function automatic logic [4:0] atlas_row(logic [1:0] kind, logic [2:0] face);
    logic [4:0] row;
    case (kind)
      KIND_GRASS: begin
        case (face)
          DIR_PY:  row = ROW_GRASS_TOP;
          DIR_NY:  row = ROW_DIRT;
          default: row = ROW_GRASS_SIDE;
        endcase
      end
      KIND_DIRT: row = ROW_DIRT;
      default:   row = ROW_STONE;
    endcase
    return row;
  endfunction

  // Apply one accepted transaction to the shadow state and queue the vertices it yields.
  // Coordinates are 4 bits on a 16-cube chunk, so none is ever out of range here.
  task automatic predict_vertices(input in_item_t it);
    int x, y, z, remaining;
    logic [1:0] center;
    logic [5:0] visible;
    logic [2:0] c;
    out_item_t v;
    x = int'(it.voxel_x);
    y = int'(it.voxel_y);
    z = int'(it.voxel_z);
    case (it.op)
      OP_WRITE_CHUNK: vox_mem[voxel_addr(x, y, z)] = it.block_kind;
      OP_WRITE_PLANE: begin
        if (it.plane_dir < FACES)
          plane_mem[it.plane_dir][plane_slot(it.plane_dir, x, y, z)] = it.block_kind;
      end
      OP_MESH: begin
        center  = vox_mem[voxel_addr(x, y, z)];
        visible = '0;
        if (center != KIND_AIR) begin
          for (int f = 0; f < FACES; f++)
            visible[f] = (neighbor_kind(3'(f), x, y, z) == KIND_AIR);
        end
        remaining = $countones(visible) * VERTS;
        for (int f = 0; f < FACES; f++) begin
          if (visible[f]) begin
            for (int n = 0; n < VERTS; n++) begin
              c = VERTEX_CORNER[f][n];
              v.corner_x    = 5'(x + c[0]);
              v.corner_y    = 5'(y + c[1]);
              v.corner_z    = 5'(z + c[2]);
              v.atlas_index = atlas_row(center, 3'(f)) + 5'(n);
              v.face_id     = 3'(f);
              remaining--;
              v.last_vertex = (remaining == 0);
              expected_vertices.push_back(v);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_error(input string msg);
    if (error_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [4:0] got, input logic [4:0] want);
    if (got !== want)
      report_error($sformatf("vertex %0d %s got %0d want %0d", vertices_seen, name, got, want));
  endtask

  task automatic check_vertex(input out_item_t got);
    out_item_t want;
    if (expected_vertices.size() == 0) begin
      report_error($sformatf("vertex %0d arrived with none expected", vertices_seen));
    end else begin
      want = expected_vertices.pop_front();
      check_field("corner_x", got.corner_x, want.corner_x);
      check_field("corner_y", got.corner_y, want.corner_y);
      check_field("corner_z", got.corner_z, want.corner_z);
      check_field("atlas_index", got.atlas_index, want.atlas_index);
      check_field("face_id", 5'(got.face_id), 5'(want.face_id));
      check_field("last_vertex", 5'(got.last_vertex), 5'(want.last_vertex));
    end
    vertices_seen++;
  endtask

  // Mostly short, now and then long.
  function automatic int burst_len(int short_max, int long_lo, int long_hi, int long_pct);
    if ($urandom_range(0, 99) < long_pct) return $urandom_range(long_lo, long_hi);
    return $urandom_range(0, short_max);
  endfunction

  // Favor the chunk faces and a small middle region so meshes share neighbors.
  function automatic int pick_coord(int size);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return size - 1;
    if (r < 7) return $urandom_range(6, 9);
    return $urandom_range(0, size - 1);
  endfunction

  task automatic push_item(input logic [1:0] op, input int x, input int y, input int z,
                           input logic [2:0] dir, input logic [1:0] kind);
    in_item_t it;
    it.op         = op;
    it.voxel_x    = CW'(x);
    it.voxel_y    = CW'(y);
    it.voxel_z    = CW'(z);
    it.plane_dir  = dir;
    it.block_kind = kind;
    if (op == OP_WRITE_CHUNK) vox_set[voxel_addr(x, y, z)] = 1'b1;
    if (op == OP_WRITE_PLANE && dir < FACES) plane_set[dir][plane_slot(dir, x, y, z)] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Load every voxel the mesh of x,y,z reads, then queue the mesh. A kind that is not KEEP
  // rewrites the center or all six neighbors with it; KEEP fills unloaded entries at random
  // and now and then overwrites a loaded neighbor. Edge planes are loaded whatever the mask says.
  task automatic mesh_block(input int x, input int y, input int z, input int center_kind,
                            input int nbr_kind, output int pushed);
    int nx, ny, nz;
    logic [2:0] face;
    logic [1:0] kind;
    pushed = 0;
    if (center_kind != KEEP || !vox_set[voxel_addr(x, y, z)]) begin
      if (center_kind != KEEP) kind = 2'(center_kind);
      else if ($urandom_range(0, 5) == 0) kind = KIND_AIR;
      else kind = 2'($urandom_range(1, 3));
      push_item(OP_WRITE_CHUNK, x, y, z, 3'($urandom_range(0, 7)), kind);
      pushed++;
    end
    for (int f = 0; f < FACES; f++) begin
      face = 3'(f);
      kind = (nbr_kind != KEEP) ? 2'(nbr_kind) : 2'($urandom_range(0, 3));
      if (step_face(face, x, y, z, nx, ny, nz)) begin
        if (nbr_kind != KEEP || !plane_set[face][plane_slot(face, x, y, z)] ||
            $urandom_range(0, 9) == 0) begin
          // Scramble the coordinate along the plane's own axis; the block ignores it.
          push_item(OP_WRITE_PLANE,
                    (face[2:1] == 2'd0) ? $urandom_range(0, 15) : x,
                    (face[2:1] == 2'd1) ? $urandom_range(0, 15) : y,
                    (face[2:1] == 2'd2) ? $urandom_range(0, 15) : z,
                    face, kind);
          pushed++;
        end
      end else if (nbr_kind != KEEP || !vox_set[voxel_addr(nx, ny, nz)] ||
                   $urandom_range(0, 9) == 0) begin
        push_item(OP_WRITE_CHUNK, nx, ny, nz, 3'($urandom_range(0, 7)), kind);
        pushed++;
      end
    end
    push_item(OP_MESH, x, y, z, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
    pushed++;
  endtask

  // Mostly well-formed load-then-mesh sequences, with stray writes and dropped items mixed in.
  // Dropped items (unused op, bad plane direction) do not count toward the phase size.
  task automatic random_phase();
    int counted, n, r;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        mesh_block(pick_coord(SIZE_X), pick_coord(SIZE_Y), pick_coord(SIZE_Z), KEEP, KEEP, n);
        counted += n;
      end else if (r < 75) begin
        push_item(OP_WRITE_CHUNK, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        counted++;
      end else if (r < 85) begin
        push_item(OP_WRITE_PLANE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), 3'($urandom_range(0, 5)), 2'($urandom_range(0, 3)));
        counted++;
      end else if (r < 93) begin
        push_item(OP_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      end else begin
        push_item(OP_WRITE_PLANE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), ($urandom_range(0, 1) == 0) ? DIR_BAD_LO : DIR_BAD_HI,
                  2'($urandom_range(0, 3)));
      end
    end
  endtask

  // Hold until every queued transaction is taken and every vertex has come, then let a
  // mesh that yields nothing finish before the register may change.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_vertices.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [5:0] mask);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_mask = mask;
    @(negedge clk);
  endtask

  // Input driver: present queued items, hold a stalled transaction, idle between items.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) predict_vertices(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap   <= ($urandom_range(0, 9) < 6) ? 0 : burst_len(3, 8, 30, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: once armed, stall the output until hold_count reaches LONG_HOLD so the
  // block backs up and stalls its input while the driver keeps offering items.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_count  <= 0;
      hold_active <= 1'b0;
    end else if (pressure_armed && hold_count < LONG_HOLD) begin
      hold_count  <= hold_count + 1;
      hold_active <= 1'b1;
    end else begin
      hold_active <= 1'b0;
    end
  end

  // Output monitor: check each accepted vertex, alternate free and stalled stretches.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_vertex(out_data);
      if (stall_left == 0) begin
        rand_stall = !rand_stall;
        stall_left = rand_stall ? burst_len(2, 8, 30, 10) : burst_len(6, 20, 80, 20);
      end else begin
        stall_left--;
      end
      out_stall <= hold_active || rand_stall;
    end
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, neighbor mask still at its reset value (all absent).
    // Drop: unused op with every field at its top value, and both bad plane directions.
    push_item(OP_NOP, SIZE_X - 1, SIZE_Y - 1, SIZE_Z - 1, DIR_BAD_HI, KIND_STONE);
    push_item(OP_WRITE_PLANE, SIZE_X - 1, SIZE_Y - 1, SIZE_Z - 1, DIR_BAD_LO, KIND_STONE);
    push_item(OP_WRITE_PLANE, 0, 0, 0, DIR_BAD_HI, KIND_GRASS);
    // Far corner grass block with air around: all six faces, corners reach 16.
    mesh_block(SIZE_X - 1, SIZE_Y - 1, SIZE_Z - 1, KIND_GRASS, KIND_AIR, n);
    // Origin dirt block boxed in by stone: only the absent-neighbor faces show.
    mesh_block(0, 0, 0, KIND_DIRT, KIND_STONE, n);
    // Air block: nothing comes out.
    push_item(OP_WRITE_CHUNK, 0, 0, 0, DIR_NX, KIND_AIR);
    push_item(OP_MESH, 0, 0, 0, DIR_PZ, KIND_STONE);
    random_phase();
    wait_drained();

    // All neighbors present; the boxed-in origin block now has no visible face.
    // Arm the long hold-off for this phase.
    write_mask(6'h3F);
    pressure_armed = 1'b1;
    mesh_block(0, 0, 0, KIND_DIRT, KIND_STONE, n);
    random_phase();
    wait_drained();

    write_mask(6'h00);
    random_phase();
    wait_drained();

    write_mask(6'($urandom_range(1, 62)));
    random_phase();
    wait_drained();

    write_mask(6'($urandom_range(0, 63)));
    random_phase();
    wait_drained();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
